### hdl/bdqs_pkg.sv
// ----------------------------------------------------------------------------
// bdqs_pkg
// shared types and codes for the bounded deque with value search
// ----------------------------------------------------------------------------
package bdqs_pkg;

    localparam int DEPTH_DEF = 256;
    localparam int VALUE_W   = 32;
    localparam int KIND_W    = 3;
    localparam int CNT_W     = 9;
    localparam int STATUS_W  = 2;

    // request kinds
    localparam logic [KIND_W-1:0] KIND_PUSH_FRONT = 3'd0;
    localparam logic [KIND_W-1:0] KIND_PUSH_BACK  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_POP_FRONT  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_POP_BACK   = 3'd3;
    localparam logic [KIND_W-1:0] KIND_COUNT      = 3'd4;
    localparam logic [KIND_W-1:0] KIND_FIND       = 3'd5;
    localparam logic [KIND_W-1:0] KIND_SIZE       = 3'd6;

    // result status
    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

    typedef logic signed [VALUE_W-1:0] t_value;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        t_value            value;
    } t_in_word;

    typedef struct packed {
        t_value              popped_value;
        logic [CNT_W-1:0]    match_count;
        logic                found;
        logic [CNT_W-1:0]    entry_count;
        logic [STATUS_W-1:0] status;
    } t_out_word;

    // per-cycle move command shared by every cell of the row
    typedef struct packed {
        logic shift_left;   // take the right neighbor's value
        logic shift_right;  // take the left neighbor's value
    } t_cell_ctl;

endpackage

### hdl/bounded_deque_with_search.sv
// ----------------------------------------------------------------------------
// bounded_deque_with_search
// bounded double-ended queue of signed values with count and find by value
// ----------------------------------------------------------------------------
//
//  channel | direction | valid        | stall        | word
//  --------+-----------+--------------+--------------+-------------
//  request | in        | i_in_valid   | o_in_stall   | i_in_word
//  result  | out       | o_out_valid  | i_out_stall  | o_out_word
//
//  push front, pop front, size and any refused push or pop: result in the cycle
//  after the request word is taken
//  push back, pop back, count and find: result after a full rotation of the
//  cell row past the head cell, one slot a cycle, then from the done state
//  one request is in work at a time; a new request word is taken only when
//  the result register is empty or hands its word on at that edge, so a
//  result word held by i_out_stall also stalls the request side
//  synchronous active-low reset clears occupancy and control; cell contents
//  are not cleared, slots beyond the occupancy are never reported
//
module bounded_deque_with_search #(
    parameter int DEPTH = bdqs_pkg::DEPTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  bdqs_pkg::t_in_word  i_in_word,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output bdqs_pkg::t_out_word o_out_word
);
    import bdqs_pkg::*;

    // cell i holds the entry at offset i from the front, so the head is cell 0
    t_value    w_cell [DEPTH];
    t_value    w_back_in;
    t_cell_ctl w_ctl;

    // sequencer: decides the row move each cycle and builds the result word
    bdqs_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word),
        .i_head      (w_cell[0]),
        .o_back_in   (w_back_in),
        .o_ctl       (w_ctl)
    );

    // row of cells
    // shift right: push at front, new value enters cell 0
    // shift left: pop at front, or one rotation step of a scan where the
    // head wraps into the last cell (or the pushed value takes its place)
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        t_value w_left;
        t_value w_right;

        if (g == 0) begin : g_first
            assign w_left = i_in_word.value;
        end else begin : g_mid_l
            assign w_left = w_cell[g-1];
        end

        if (g == DEPTH - 1) begin : g_last
            assign w_right = w_back_in;
        end else begin : g_mid_r
            assign w_right = w_cell[g+1];
        end

        bdqs_cell u_cell (
            .i_clk        (i_clk),
            .i_ctl        (w_ctl),
            .i_from_left  (w_left),
            .i_from_right (w_right),
            .o_value      (w_cell[g])
        );
    end

endmodule

### hdl/bdqs_cell.sv
// ----------------------------------------------------------------------------
// bdqs_cell
// one storage cell of the deque row, holds one value and moves it left or right
// ----------------------------------------------------------------------------
module bdqs_cell (
    input  logic                i_clk,
    input  bdqs_pkg::t_cell_ctl i_ctl,
    input  bdqs_pkg::t_value    i_from_left,
    input  bdqs_pkg::t_value    i_from_right,
    output bdqs_pkg::t_value    o_value
);
    import bdqs_pkg::*;

    t_value r_value;
    t_value n_value;

    always_comb begin
        if (i_ctl.shift_right) begin
            n_value = i_from_left;
        end else if (i_ctl.shift_left) begin
            n_value = i_from_right;
        end else begin
            n_value = r_value;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value = r_value;

endmodule

### hdl/bdqs_ctrl.sv
// ----------------------------------------------------------------------------
// bdqs_ctrl
// request sequencer: occupancy, ring rotation scan and the output register
// ----------------------------------------------------------------------------
module bdqs_ctrl #(
    parameter int DEPTH = bdqs_pkg::DEPTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  bdqs_pkg::t_in_word  i_in_word,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output bdqs_pkg::t_out_word o_out_word,
    input  bdqs_pkg::t_value    i_head,
    output bdqs_pkg::t_value    o_back_in,
    output bdqs_pkg::t_cell_ctl o_ctl
);
    import bdqs_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = $clog2(DEPTH);
    localparam logic [SW-1:0] LAST_STEP = SW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_OCC  = CW'(DEPTH);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_DONE = 3'b100
    } t_state;

    t_state            r_state, n_state;
    logic [CW-1:0]     r_occ, n_occ;
    logic [SW-1:0]     r_step, n_step;
    logic [KIND_W-1:0] r_kind, n_kind;
    t_value            r_key, n_key;
    t_value            r_popped, n_popped;
    logic [CW-1:0]     r_matches, n_matches;
    logic              r_found, n_found;
    logic              r_out_valid, n_out_valid;
    t_out_word         r_out_word, n_out_word;

    logic          w_accept;
    logic          w_full;
    logic          w_empty;
    logic          w_out_free;
    logic [CW-1:0] w_step_ext;
    logic          w_live;
    logic          w_hit;
    logic          w_inject;

    assign w_out_free = !r_out_valid || !i_out_stall;
    assign o_in_stall = (r_state != ST_IDLE) || !w_out_free;
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_full     = (r_occ == FULL_OCC);
    assign w_empty    = (r_occ == '0);

    // during a scan the head cell holds the entry at offset r_step
    assign w_step_ext = CW'(r_step);
    assign w_live     = (w_step_ext < r_occ);
    assign w_hit      = w_live && (i_head == r_key);
    assign w_inject   = (r_state == ST_SCAN) && (r_kind == KIND_PUSH_BACK)
                        && (w_step_ext == r_occ);
    assign o_back_in  = w_inject ? r_key : i_head;

    always_comb begin
        n_state     = r_state;
        n_occ       = r_occ;
        n_step      = r_step;
        n_kind      = r_kind;
        n_key       = r_key;
        n_popped    = r_popped;
        n_matches   = r_matches;
        n_found     = r_found;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_word  = r_out_word;
        o_ctl       = '0;

        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_out_word              = '0;
                    n_out_word.entry_count  = CNT_W'(r_occ);
                    n_out_word.status       = STATUS_OK;
                    n_kind                  = i_in_word.kind;
                    n_key                   = i_in_word.value;
                    n_step                  = '0;
                    n_popped                = '0;
                    n_matches               = '0;
                    n_found                 = 1'b0;
                    case (i_in_word.kind)
                        KIND_PUSH_FRONT: begin
                            n_out_valid = 1'b1;
                            if (w_full) begin
                                n_out_word.status = STATUS_FULL;
                            end else begin
                                o_ctl.shift_right      = 1'b1;
                                n_occ                  = r_occ + 1'b1;
                                n_out_word.entry_count = CNT_W'(r_occ + 1'b1);
                            end
                        end
                        KIND_PUSH_BACK: begin
                            if (w_full) begin
                                n_out_valid       = 1'b1;
                                n_out_word.status = STATUS_FULL;
                            end else begin
                                n_state = ST_SCAN;
                            end
                        end
                        KIND_POP_FRONT: begin
                            n_out_valid = 1'b1;
                            if (w_empty) begin
                                n_out_word.status = STATUS_EMPTY;
                            end else begin
                                o_ctl.shift_left        = 1'b1;
                                n_occ                   = r_occ - 1'b1;
                                n_out_word.popped_value = i_head;
                                n_out_word.entry_count  = CNT_W'(r_occ - 1'b1);
                            end
                        end
                        KIND_POP_BACK: begin
                            if (w_empty) begin
                                n_out_valid       = 1'b1;
                                n_out_word.status = STATUS_EMPTY;
                            end else begin
                                n_state = ST_SCAN;
                            end
                        end
                        KIND_COUNT, KIND_FIND: begin
                            n_state = ST_SCAN;
                        end
                        default: begin
                            n_out_valid = 1'b1;
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                o_ctl.shift_left = 1'b1;
                n_step           = r_step + 1'b1;
                if ((r_kind == KIND_COUNT) && w_hit) begin
                    n_matches = r_matches + 1'b1;
                end
                if ((r_kind == KIND_FIND) && w_hit) begin
                    n_found = 1'b1;
                end
                if ((r_kind == KIND_POP_BACK) && (w_step_ext == r_occ - 1'b1)) begin
                    n_popped = i_head;
                end
                if (r_step == LAST_STEP) begin
                    n_state = ST_DONE;
                    n_step  = '0;
                    if (r_kind == KIND_PUSH_BACK) begin
                        n_occ = r_occ + 1'b1;
                    end else if (r_kind == KIND_POP_BACK) begin
                        n_occ = r_occ - 1'b1;
                    end
                end
            end
            ST_DONE: begin
                if (w_out_free) begin
                    n_state                 = ST_IDLE;
                    n_out_valid             = 1'b1;
                    n_out_word.popped_value = r_popped;
                    n_out_word.match_count  = CNT_W'(r_matches);
                    n_out_word.found        = r_found;
                    n_out_word.entry_count  = CNT_W'(r_occ);
                    n_out_word.status       = STATUS_OK;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_occ       <= '0;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_occ       <= n_occ;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind     <= n_kind;
        r_key      <= n_key;
        r_popped   <= n_popped;
        r_matches  <= n_matches;
        r_found    <= n_found;
        r_out_word <= n_out_word;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

`ifndef SYNTH
    // occupancy stays within the row
    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ <= FULL_OCC)
        else $error("occupancy above depth");

    // the row never moves both ways in one cycle
    a_one_dir: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_ctl.shift_left && o_ctl.shift_right))
        else $error("cells shifted both ways");

    // a scan runs the full ring before finishing
    a_scan_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) && (r_step != LAST_STEP) |=> (r_state == ST_SCAN))
        else $error("scan ended early");

    // occupancy moves by at most one per request
    a_occ_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (r_occ == $past(r_occ)) || (r_occ == $past(r_occ) + 1'b1)
                           || (r_occ == $past(r_occ) - 1'b1))
        else $error("occupancy jumped");

    // a finished scan result is only delivered from the done state
    a_done_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> !n_out_valid || r_out_valid)
        else $error("word issued during scan");
`endif

endmodule

### tb/deque_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deque_checker
// watches both channels of the deque, predicts every result word from the
// accepted request words and compares them field by field, in order
// ----------------------------------------------------------------------------
module deque_checker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_stall,
    input  bdqs_pkg::t_in_word  i_in_word,
    input  logic                i_out_valid,
    input  logic                i_out_stall,
    input  bdqs_pkg::t_out_word i_out_word,
    output int                  o_fail_count,
    output int                  o_pending,
    output int                  o_result_count
);
    import bdqs_pkg::*;

    localparam int DEPTH      = DEPTH_DEF;
    localparam int REPORT_CAP = 40;

    t_value    slots [DEPTH];
    int        head;
    int        fill;
    int        fails;
    int        results;
    t_out_word awaited_results [$];

    // applies one request to the shadow deque and returns its result word
    function automatic t_out_word deque_apply(t_in_word req);
        t_out_word res;
        res = '0;
        case (req.kind)
            KIND_PUSH_FRONT, KIND_PUSH_BACK: begin
                if (fill == DEPTH) begin
                    res.status = STATUS_FULL;
                end else if (req.kind == KIND_PUSH_FRONT) begin
                    head = (head + DEPTH - 1) % DEPTH;
                    slots[head] = req.value;
                    fill++;
                end else begin
                    slots[(head + fill) % DEPTH] = req.value;
                    fill++;
                end
            end
            KIND_POP_FRONT, KIND_POP_BACK: begin
                if (fill == 0) begin
                    res.status = STATUS_EMPTY;
                end else if (req.kind == KIND_POP_FRONT) begin
                    res.popped_value = slots[head];
                    head = (head + 1) % DEPTH;
                    fill--;
                end else begin
                    res.popped_value = slots[(head + fill - 1) % DEPTH];
                    fill--;
                end
            end
            KIND_COUNT, KIND_FIND: begin
                for (int i = 0; i < fill; i++) begin
                    if (slots[(head + i) % DEPTH] == req.value) begin
                        if (req.kind == KIND_COUNT)
                            res.match_count = res.match_count + 1'b1;
                        else
                            res.found = 1'b1;
                    end
                end
            end
            default: ;  // size and the unused kind leave the deque alone
        endcase
        res.entry_count = CNT_W'(fill);
        return res;
    endfunction

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want !== got) begin
            fails++;
            if (fails <= REPORT_CAP)
                $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        t_out_word want;
        if (!i_rst_n) begin
            head = 0;
            fill = 0;
            awaited_results.delete();
        end else begin
            // result first: a request taken at this edge cannot answer yet
            if (i_out_valid && !i_out_stall) begin
                results++;
                if (awaited_results.size() == 0) begin
                    fails++;
                    if (fails <= REPORT_CAP)
                        $error("result word 0x%0h with no request waiting", i_out_word);
                end else begin
                    want = awaited_results.pop_front();
                    compare_field("popped_value", want.popped_value, i_out_word.popped_value);
                    compare_field("match_count", want.match_count, i_out_word.match_count);
                    compare_field("found", want.found, i_out_word.found);
                    compare_field("entry_count", want.entry_count, i_out_word.entry_count);
                    compare_field("status", want.status, i_out_word.status);
                end
            end
            if (i_in_valid && !i_in_stall)
                awaited_results.push_back(deque_apply(i_in_word));
        end
        o_pending      <= awaited_results.size();
        o_fail_count   <= fails;
        o_result_count <= results;
    end

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// drives request words into the bounded deque under three stall profiles,
// a directed opening, a warm-up, a fill to full, a drain and mixed traffic; the checker
// beside the block predicts and compares every result word
// ----------------------------------------------------------------------------
module tb_top;
    import bdqs_pkg::*;

    localparam int DEPTH         = DEPTH_DEF;
    localparam int ITEM_BUDGET   = 570;     // request words in the whole run
    localparam int WARM_ITEMS    = 70;      // mixed traffic before the fill
    localparam int PHASE_A_END   = 190;     // sender idles lightly, receiver heavily
    localparam int PHASE_B_END   = 380;     // the other way round, then no idling
    localparam int SETTLE_CYCLES = DEPTH + 16;
    localparam int POOL_SIZE     = 6;

    // kind 7 has no operation of its own and behaves as size
    localparam logic [KIND_W-1:0] KIND_UNUSED = 3'd7;
    localparam t_value VALUE_MAX = 32'sh7fff_ffff;
    localparam t_value VALUE_MIN = 32'sh8000_0000;

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    t_in_word  i_in_word   = '0;
    logic      i_out_stall = 1'b0;
    logic      o_in_stall;
    logic      o_out_valid;
    t_out_word o_out_word;

    int        fail_count;
    int        pending;
    int        result_count;
    int        recv_idle  = 84;   // percent of cycles the receiver stalls
    int        n_sent     = 0;
    int        level      = 0;    // entries held, only to steer the stimulus
    int        peak_level = 0;
    t_value    flood;             // the one value the fill phase pushes
    t_value    pool [POOL_SIZE];  // small set of repeats so count and find hit

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    bounded_deque_with_search u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word)
    );

    deque_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .i_in_stall     (o_in_stall),
        .i_in_word      (i_in_word),
        .i_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .i_out_word     (o_out_word),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_result_count (result_count)
    );

    // receiver stalls at random, rate set by the current phase
    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < recv_idle);
    end

    // values: the signed extremes, zero and minus one, pool repeats, anything
    function automatic t_value rand_value();
        case ($urandom_range(9))
            0:          return $urandom_range(1) ? VALUE_MAX : VALUE_MIN;
            1:          return $urandom_range(1) ? t_value'(0) : t_value'(-1);
            2, 3, 4, 5: return pool[$urandom_range(POOL_SIZE - 1)];
            default:    return t_value'($urandom);
        endcase
    endfunction

    // offers one request word and returns at the edge that takes it;
    // valid stays high into the next word unless an idle gap is drawn
    task automatic send_word(input logic [KIND_W-1:0] kind, input t_value value);
        int send_idle;
        if (n_sent < PHASE_A_END) begin
            send_idle = 30;
            recv_idle <= 84;
        end else if (n_sent < PHASE_B_END) begin
            send_idle = 84;
            recv_idle <= 30;
        end else begin
            send_idle = 0;
            recv_idle <= 0;
        end
        if ($urandom_range(99) < send_idle) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle);
        end
        i_in_valid      <= 1'b1;
        i_in_word.kind  <= kind;
        i_in_word.value <= value;
        do @(posedge i_clk); while (o_in_stall);
        n_sent++;
        // refused pushes and pops leave the level as it is
        if ((kind == KIND_PUSH_FRONT || kind == KIND_PUSH_BACK) && level < DEPTH)
            level++;
        else if ((kind == KIND_POP_FRONT || kind == KIND_POP_BACK) && level > 0)
            level--;
        if (level > peak_level)
            peak_level = level;
    endtask

    // general traffic: half pushes, a quarter pops, the rest queries
    task automatic send_mixed();
        int pick;
        pick = $urandom_range(19);
        if (pick < 10)
            send_word(pick[0] ? KIND_PUSH_BACK : KIND_PUSH_FRONT, rand_value());
        else if (pick < 15)
            send_word(pick[0] ? KIND_POP_BACK : KIND_POP_FRONT, t_value'($urandom));
        else if (pick < 17)
            send_word(KIND_COUNT, rand_value());
        else if (pick == 17)
            send_word(KIND_FIND, rand_value());
        else if (pick == 18)
            send_word(KIND_SIZE, t_value'($urandom));
        else
            send_word(KIND_UNUSED, t_value'($urandom));
    endtask

    initial begin
        for (int i = 0; i < POOL_SIZE; i++)
            pool[i] = t_value'($urandom);
        flood = t_value'($urandom);

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: everything on an empty deque first
        send_word(KIND_POP_FRONT, t_value'(0));
        send_word(KIND_POP_BACK, t_value'(0));
        send_word(KIND_COUNT, t_value'(0));
        send_word(KIND_FIND, t_value'(0));
        send_word(KIND_SIZE, t_value'(0));
        send_word(KIND_UNUSED, t_value'(0));
        // extremes from both ends, deque reads -1, min, max, 0
        send_word(KIND_PUSH_BACK, VALUE_MAX);
        send_word(KIND_PUSH_FRONT, VALUE_MIN);
        send_word(KIND_PUSH_BACK, t_value'(0));
        send_word(KIND_PUSH_FRONT, t_value'(-1));
        send_word(KIND_COUNT, t_value'(0));
        send_word(KIND_FIND, VALUE_MIN);
        send_word(KIND_FIND, t_value'(1));        // absent value
        send_word(KIND_PUSH_BACK, VALUE_MIN);
        send_word(KIND_COUNT, VALUE_MIN);          // two matches
        send_word(KIND_SIZE, t_value'(-1));
        send_word(KIND_UNUSED, VALUE_MAX);
        // drain from alternating ends down to a single entry
        send_word(KIND_POP_BACK, t_value'(0));
        send_word(KIND_POP_FRONT, t_value'(0));
        send_word(KIND_POP_BACK, t_value'(0));
        send_word(KIND_POP_FRONT, t_value'(0));
        // back pop with a single entry held
        send_word(KIND_POP_BACK, t_value'(0));
        // front pop with a single entry held, then pop once more on empty
        send_word(KIND_PUSH_BACK, t_value'(32'sh5a5a_a5a5));
        send_word(KIND_POP_FRONT, t_value'(0));
        send_word(KIND_POP_FRONT, t_value'(0));

        // warm-up with random content
        repeat (WARM_ITEMS) send_mixed();

        // empty it so the fill below ends with every slot equal
        while (level != 0)
            send_word($urandom_range(1) ? KIND_POP_BACK : KIND_POP_FRONT, rand_value());

        // fill to full from both ends, queries sprinkled in along the way
        while (level != DEPTH) begin
            if ($urandom_range(19) == 0)
                send_word($urandom_range(1) ? KIND_COUNT : KIND_FIND, flood);
            else
                send_word($urandom_range(1) ? KIND_PUSH_BACK : KIND_PUSH_FRONT, flood);
        end
        // pushes refused at both ends, then a count that matches every slot
        send_word(KIND_PUSH_FRONT, rand_value());
        send_word(KIND_PUSH_BACK, rand_value());
        send_word(KIND_COUNT, flood);
        send_word(KIND_FIND, ~flood);
        send_word(KIND_SIZE, t_value'($urandom));

        // drain, mostly pops, until empty or out of budget
        while (level != 0 && n_sent < ITEM_BUDGET) begin
            if ($urandom_range(9) == 0)
                send_word($urandom_range(1) ? KIND_COUNT : KIND_FIND,
                          $urandom_range(1) ? flood : rand_value());
            else
                send_word($urandom_range(1) ? KIND_POP_BACK : KIND_POP_FRONT,
                          t_value'($urandom));
        end

        while (n_sent < ITEM_BUDGET)
            send_mixed();

        i_in_valid <= 1'b0;
        // one edge so the count of waiting results includes the last word
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
        // catch any stray result word after the last expected one
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("covered %0d request words under three stall profiles, peak depth %0d of %0d",
                 n_sent, peak_level, DEPTH);
        $display("%0d result words compared, %0d failures", result_count, fail_count);
        if (fail_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // watchdog, well beyond the slowest legal run
    initial begin
        #(20_000_000);
        $display("run timed out with %0d result words outstanding", pending);
        $display("end of test: mismatches");
        $finish;
    end

endmodule

### filelist.f
hdl/bdqs_pkg.sv
hdl/bdqs_cell.sv
hdl/bdqs_ctrl.sv
hdl/bounded_deque_with_search.sv
tb/deque_checker.sv
tb/tb_top.sv
